FILE: rtl/adaptive_line_follower_pid_core_macros.svh
// Assertion macros used by the RTL of the line follower core.
`ifndef ADAPTIVE_LINE_FOLLOWER_PID_CORE_MACROS_SVH
`define ADAPTIVE_LINE_FOLLOWER_PID_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ALFP_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("alfp check failed");
`define ALFP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alfp sequence check failed");
`else
`define ALFP_CHECK(lbl, cond)
`define ALFP_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/alfp_pkg.sv
package alfp_pkg;

  localparam int SAMPLE_BITS       = 12;
  localparam int INTEGRAL_BITS_DEF = 24;
  localparam int GAIN_BITS         = 24;
  localparam int SPEED_BITS        = 15;
  localparam int OUT_BITS          = 16;
  localparam int THRESH_BITS       = 12;
  localparam int WEIGHT_BITS       = 13;
  localparam int FRAC_BITS         = 12;
  localparam int ERR_BITS          = 15;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int CFG_DATA_BITS     = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TO_DARK     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TO_WHITE    = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING   = 3'd7;

  localparam logic [GAIN_BITS-1:0]   GAIN_P_RESET      = 24'd491520;
  localparam logic [GAIN_BITS-1:0]   GAIN_I_RESET      = 24'd66;
  localparam logic [GAIN_BITS-1:0]   GAIN_D_RESET      = 24'd262144;
  localparam logic [SPEED_BITS-1:0]  BASE_SPEED_RESET  = 15'd12288;
  localparam logic [SPEED_BITS-1:0]  SPEED_LIMIT_RESET = 15'd12288;
  localparam logic [THRESH_BITS-1:0] TO_DARK_RESET     = 12'd2458;
  localparam logic [THRESH_BITS-1:0] TO_WHITE_RESET    = 12'd1638;
  localparam logic [WEIGHT_BITS-1:0] SMOOTHING_RESET   = 13'd410;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE        = 13'd4096;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sensor_far_left;
    logic [SAMPLE_BITS-1:0] sensor_left;
    logic [SAMPLE_BITS-1:0] sensor_center;
    logic [SAMPLE_BITS-1:0] sensor_right;
    logic [SAMPLE_BITS-1:0] sensor_far_right;
  } sensor_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] left_wheel_speed;
    logic signed [OUT_BITS-1:0] right_wheel_speed;
    logic                       white_line_active;
  } drive_t;

endpackage

FILE: rtl/adaptive_line_follower_pid_core.sv
// Channel   Signals                                    Direction
// in        in_valid, in_ready, in_data (sensor_t)     sensor beats into the core
// out       out_valid, out_ready, out_data (drive_t)   drive beats out of the core
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  register writes, always ready
//
// A beat passes the restoring divider (one quotient bit per cycle, used for the mean and the centroid),
// a 13-step loop that forms the average and the 24-step shift-add gain loop, then returns to idle.
// A new beat is taken in idle even while the previous result waits in the output register.
// A stalled output holds the core in its last step until the result register frees up.
// Synchronous reset restores registers, clears the average and integral, selects white mode.
`include "adaptive_line_follower_pid_core_macros.svh"

module adaptive_line_follower_pid_core import alfp_pkg::*; #(
  parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sensor_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output drive_t                    out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SUM_BITS   = SAMPLE_BITS + 3;
  localparam int DIV_BITS   = SAMPLE_BITS + 2 + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(DIV_BITS + 1);
  localparam int SACC_BITS  = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int MUL_BITS   = GAIN_BITS + INTEGRAL_BITS + 2;
  localparam int CORR_BITS  = MUL_BITS - 15;
  localparam int CLAMP_BITS = CORR_BITS + 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MEAN   = 4'd1;
  localparam logic [3:0] ST_SMSET  = 4'd2;
  localparam logic [3:0] ST_SMOOTH = 4'd3;
  localparam logic [3:0] ST_MODE   = 4'd4;
  localparam logic [3:0] ST_ERRSET = 4'd5;
  localparam logic [3:0] ST_ERRDIV = 4'd6;
  localparam logic [3:0] ST_PID    = 4'd7;
  localparam logic [3:0] ST_MULT   = 4'd8;
  localparam logic [3:0] ST_ROUND  = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [GAIN_BITS-1:0]   gain_p, gain_i, gain_d;
  logic [SPEED_BITS-1:0]  cruise_speed, speed_limit;
  logic [THRESH_BITS-1:0] to_dark, to_white;
  logic [WEIGHT_BITS-1:0] smoothing_weight;

  logic [SAMPLE_BITS-1:0]          smoothed;
  logic                            white_mode;
  logic signed [INTEGRAL_BITS-1:0] integ;
  logic signed [ERR_BITS-1:0]      prev_err;

  logic [3:0]             state;
  logic [CNT_BITS-1:0]    cnt;
  logic [SAMPLE_BITS-1:0] samp [5];
  logic [SUM_BITS-1:0]    rem;
  logic [SUM_BITS-1:0]    divisor;
  logic [DIV_BITS-1:0]    dq;
  logic                   neg;
  logic signed [SACC_BITS-1:0] sacc, sop;
  logic [WEIGHT_BITS-1:0] wsh;
  logic signed [MUL_BITS-1:0]  macc, op_e, op_i, op_d;
  logic [GAIN_BITS-1:0]   gp_sh, gi_sh, gd_sh;
  logic signed [CORR_BITS-1:0] corr;

  logic [SUM_BITS-1:0]   in_total;
  logic [SUM_BITS+1:0]   trial;
  logic [SAMPLE_BITS-1:0] eff [5];
  logic [SUM_BITS-1:0]   lin_sum;
  logic [SAMPLE_BITS+1:0] pos_sum, neg_sum, mag_w;
  logic [SAMPLE_BITS-1:0] sm_new;
  logic signed [ERR_BITS-1:0]      err_val;
  logic signed [INTEGRAL_BITS:0]   integ_sum;
  logic signed [INTEGRAL_BITS-1:0] integ_sat;
  logic signed [ERR_BITS:0]        dif_val;
  logic signed [MUL_BITS-1:0]      mul_add;
  logic [MUL_BITS-1:0]             mul_mag;
  logic [CORR_BITS-2:0]            rnd;
  logic signed [CLAMP_BITS-1:0]    lim_s, lsp, rsp, lcl, rcl;
  logic                            out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    in_total = SUM_BITS'(in_data.sensor_far_left) + SUM_BITS'(in_data.sensor_left)
             + SUM_BITS'(in_data.sensor_center) + SUM_BITS'(in_data.sensor_right)
             + SUM_BITS'(in_data.sensor_far_right);
    trial = {1'b0, rem, dq[DIV_BITS-1]} - {2'b00, divisor};
    for (int k = 0; k < 5; k++) begin
      eff[k] = white_mode ? ~samp[k] : samp[k];
    end
    lin_sum = SUM_BITS'(eff[0]) + SUM_BITS'(eff[1]) + SUM_BITS'(eff[2])
            + SUM_BITS'(eff[3]) + SUM_BITS'(eff[4]);
    pos_sum = {1'b0, eff[4], 1'b0} + (SAMPLE_BITS+2)'(eff[3]);
    neg_sum = {1'b0, eff[0], 1'b0} + (SAMPLE_BITS+2)'(eff[1]);
    mag_w   = (neg_sum > pos_sum) ? neg_sum - pos_sum : pos_sum - neg_sum;
    sm_new  = sacc[FRAC_BITS +: SAMPLE_BITS];
    err_val = neg ? -$signed({1'b0, dq[ERR_BITS-2:0]}) : $signed({1'b0, dq[ERR_BITS-2:0]});
    integ_sum = (INTEGRAL_BITS+1)'(integ) + (INTEGRAL_BITS+1)'(err_val);
    if (integ_sum[INTEGRAL_BITS] != integ_sum[INTEGRAL_BITS-1]) begin
      integ_sat = integ_sum[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                                           : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEGRAL_BITS-1:0];
    end
    dif_val = (ERR_BITS+1)'(err_val) - (ERR_BITS+1)'(prev_err);
    mul_add = (gp_sh[0] ? op_e : '0) + (gi_sh[0] ? op_i : '0) + (gd_sh[0] ? op_d : '0);
    mul_mag = macc[MUL_BITS-1] ? MUL_BITS'(-macc) : MUL_BITS'(macc);
    rnd     = (CORR_BITS-1)'((mul_mag + MUL_BITS'(32768)) >> 16);
    lim_s   = CLAMP_BITS'({1'b0, speed_limit});
    lsp     = CLAMP_BITS'({1'b0, cruise_speed}) - CLAMP_BITS'(corr);
    rsp     = CLAMP_BITS'({1'b0, cruise_speed}) + CLAMP_BITS'(corr);
    lcl     = (lsp > lim_s) ? lim_s : ((lsp < -lim_s) ? -lim_s : lsp);
    rcl     = (rsp > lim_s) ? lim_s : ((rsp < -lim_s) ? -lim_s : rsp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= GAIN_P_RESET;
      gain_i           <= GAIN_I_RESET;
      gain_d           <= GAIN_D_RESET;
      cruise_speed     <= BASE_SPEED_RESET;
      speed_limit      <= SPEED_LIMIT_RESET;
      to_dark          <= TO_DARK_RESET;
      to_white         <= TO_WHITE_RESET;
      smoothing_weight <= SMOOTHING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:      gain_p <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_I:      gain_i <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_D:      gain_d <= cfg_data[GAIN_BITS-1:0];
        REG_BASE_SPEED:  cruise_speed <= cfg_data[SPEED_BITS-1:0];
        REG_SPEED_LIMIT: speed_limit <= cfg_data[SPEED_BITS-1:0];
        REG_TO_DARK:     to_dark <= cfg_data[THRESH_BITS-1:0];
        REG_TO_WHITE:    to_white <= cfg_data[THRESH_BITS-1:0];
        REG_SMOOTHING:   smoothing_weight <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      smoothed  <= '0;
      white_mode <= 1'b1;
      integ     <= '0;
      prev_err  <= '0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state) inside
        ST_IDLE: begin
          if (in_valid) begin
            samp[0] <= in_data.sensor_far_left;
            samp[1] <= in_data.sensor_left;
            samp[2] <= in_data.sensor_center;
            samp[3] <= in_data.sensor_right;
            samp[4] <= in_data.sensor_far_right;
            dq      <= {in_total, {(DIV_BITS-SUM_BITS){1'b0}}};
            rem     <= '0;
            divisor <= SUM_BITS'(5);
            cnt     <= CNT_BITS'(SUM_BITS);
            state   <= ST_MEAN;
          end
        end
        ST_MEAN, ST_ERRDIV: begin
          if (!trial[SUM_BITS+1]) begin
            rem <= trial[SUM_BITS-1:0];
          end else begin
            rem <= {rem[SUM_BITS-2:0], dq[DIV_BITS-1]};
          end
          dq  <= {dq[DIV_BITS-2:0], !trial[SUM_BITS+1]};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_BITS'(1)) begin
            state <= (state == ST_MEAN) ? ST_SMSET : ST_PID;
          end
        end
        ST_SMSET: begin
          wsh   <= (smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : smoothing_weight;
          sacc  <= SACC_BITS'({smoothed, {FRAC_BITS{1'b0}}}) + SACC_BITS'(2048);
          sop   <= SACC_BITS'(dq[SAMPLE_BITS-1:0]) - SACC_BITS'(smoothed);
          cnt   <= CNT_BITS'(WEIGHT_BITS);
          state <= ST_SMOOTH;
        end
        ST_SMOOTH: begin
          if (wsh[0]) begin
            sacc <= sacc + sop;
          end
          sop   <= sop <<< 1;
          wsh   <= wsh >> 1;
          cnt   <= cnt - 1'b1;
          if (cnt == CNT_BITS'(1)) begin
            state <= ST_MODE;
          end
        end
        ST_MODE: begin
          smoothed <= sm_new;
          if (white_mode && sm_new > to_dark) begin
            white_mode <= 1'b0;
          end else if (!white_mode && sm_new < to_white) begin
            white_mode <= 1'b1;
          end
          state <= ST_ERRSET;
        end
        ST_ERRSET: begin
          neg     <= neg_sum > pos_sum;
          dq      <= {mag_w, {FRAC_BITS{1'b0}}};
          rem     <= '0;
          divisor <= (lin_sum == '0) ? SUM_BITS'(1) : lin_sum;
          cnt     <= CNT_BITS'(DIV_BITS);
          state   <= ST_ERRDIV;
        end
        ST_PID: begin
          integ    <= integ_sat;
          prev_err <= err_val;
          op_e     <= MUL_BITS'(err_val);
          op_i     <= MUL_BITS'(integ_sat);
          op_d     <= MUL_BITS'(dif_val);
          gp_sh    <= gain_p;
          gi_sh    <= gain_i;
          gd_sh    <= gain_d;
          macc     <= '0;
          cnt      <= CNT_BITS'(GAIN_BITS);
          state    <= ST_MULT;
        end
        ST_MULT: begin
          macc  <= macc + mul_add;
          op_e  <= op_e <<< 1;
          op_i  <= op_i <<< 1;
          op_d  <= op_d <<< 1;
          gp_sh <= gp_sh >> 1;
          gi_sh <= gi_sh >> 1;
          gd_sh <= gd_sh >> 1;
          cnt   <= cnt - 1'b1;
          if (cnt == CNT_BITS'(1)) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          corr  <= macc[MUL_BITS-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data.left_wheel_speed  <= lcl[OUT_BITS-1:0];
            out_data.right_wheel_speed <= rcl[OUT_BITS-1:0];
            out_data.white_line_active <= white_mode;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ALFP_NEXT(a_accept_starts_mean, in_valid && in_ready, state == ST_MEAN)
  `ALFP_CHECK(a_error_in_range, state != ST_PID || dq <= DIV_BITS'(8192))
  `ALFP_CHECK(a_average_fits, state != ST_MODE || sacc[SACC_BITS-1:FRAC_BITS+SAMPLE_BITS] == '0)
  `ALFP_NEXT(a_stall_holds_done, state == ST_DONE && out_valid && !out_ready, state == ST_DONE)

endmodule

FILE: verif/adaptive_line_follower_pid_core_tb.sv
`timescale 1ns / 1ps

module adaptive_line_follower_pid_core_tb;
  import alfp_pkg::*;

  localparam int SENSOR_BITS = $bits(sensor_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sensor_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  drive_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  adaptive_line_follower_pid_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  logic [23:0] kp, ki, kd;
  logic [14:0] base_spd, spd_lim;
  logic [11:0] dark_th, white_th;
  logic [12:0] smooth_w;
  logic [11:0] avg_bright;
  logic white_pol;
  longint integ, last_err;

  sensor_t sensor_q[$];
  drive_t drive_q[$];
  int mismatches = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;
  bit hold_in = 0;

  task automatic predict_drive(input sensor_t s);
    longint smp[5];
    longint tot, w, acc, wsum, err, nxt, corr, mag, l, r;
    drive_t d;
    smp[0] = longint'(s.sensor_far_left);
    smp[1] = longint'(s.sensor_left);
    smp[2] = longint'(s.sensor_center);
    smp[3] = longint'(s.sensor_right);
    smp[4] = longint'(s.sensor_far_right);
    tot = smp[0] + smp[1] + smp[2] + smp[3] + smp[4];
    w = (smooth_w > 4096) ? 4096 : longint'(smooth_w);
    acc = w * (tot / 5) + (4096 - w) * longint'(avg_bright) + 2048;
    avg_bright = 12'(acc >>> 12);
    if (white_pol && avg_bright > dark_th) white_pol = 1'b0;
    else if (!white_pol && avg_bright < white_th) white_pol = 1'b1;
    if (white_pol) for (int i = 0; i < 5; i++) smp[i] = 4095 - smp[i];
    tot = smp[0] + smp[1] + smp[2] + smp[3] + smp[4];
    wsum = -2 * smp[0] - smp[1] + smp[3] + 2 * smp[4];
    if (tot == 0) tot = 1;
    mag = ((wsum < 0) ? -wsum : wsum) * 4096 / tot;
    err = (wsum < 0) ? -mag : mag;
    nxt = integ + err;
    if (nxt > 8388607) nxt = 8388607;
    if (nxt < -8388608) nxt = -8388608;
    integ = nxt;
    acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * (err - last_err);
    last_err = err;
    mag = (((acc < 0) ? -acc : acc) + 32768) >>> 16;
    corr = (acc < 0) ? -mag : mag;
    l = longint'(base_spd) - corr;
    r = longint'(base_spd) + corr;
    if (l > longint'(spd_lim)) l = longint'(spd_lim);
    if (l < -longint'(spd_lim)) l = -longint'(spd_lim);
    if (r > longint'(spd_lim)) r = longint'(spd_lim);
    if (r < -longint'(spd_lim)) r = -longint'(spd_lim);
    d.left_wheel_speed = l[15:0];
    d.right_wheel_speed = r[15:0];
    d.white_line_active = white_pol;
    drive_q.push_back(d);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GAIN_P: kp = val;
      REG_GAIN_I: ki = val;
      REG_GAIN_D: kd = val;
      REG_BASE_SPEED: base_spd = val[14:0];
      REG_SPEED_LIMIT: spd_lim = val[14:0];
      REG_TO_DARK: dark_th = val[11:0];
      REG_TO_WHITE: white_th = val[11:0];
      REG_SMOOTHING: smooth_w = val[12:0];
      default: ;
    endcase
  endtask

  task automatic drain_frames();
    do @(negedge clk); while (sensor_q.size() != 0 || in_valid || drive_q.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic sensor_t rand_frame(input int shape);
    sensor_t s;
    s = SENSOR_BITS'({$urandom, $urandom});
    case (shape)
      0: begin
        s.sensor_far_left = SAMPLE_BITS'($urandom_range(0, 600));
        s.sensor_left = SAMPLE_BITS'($urandom_range(0, 1500));
        s.sensor_center = SAMPLE_BITS'($urandom_range(2500, 4095));
        s.sensor_right = SAMPLE_BITS'($urandom_range(0, 1500));
        s.sensor_far_right = SAMPLE_BITS'($urandom_range(0, 600));
      end
      1: begin
        s.sensor_far_left = SAMPLE_BITS'($urandom_range(3500, 4095));
        s.sensor_left = SAMPLE_BITS'($urandom_range(3000, 4095));
        s.sensor_center = SAMPLE_BITS'($urandom_range(1000, 4095));
        s.sensor_right = SAMPLE_BITS'($urandom_range(3000, 4095));
        s.sensor_far_right = SAMPLE_BITS'($urandom_range(3500, 4095));
      end
      2: s = $urandom_range(0, 1) ? '0 : '1;
      default: ;
    endcase
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      predict_drive(in_data);
      if (sensor_q.size() > 0 && !hold_in && (quiet_in || $urandom_range(0, 99) >= 18)) begin
        in_data <= sensor_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && sensor_q.size() > 0 && !hold_in &&
                 (quiet_in || $urandom_range(0, 99) >= 18)) begin
      in_valid <= 1'b1;
      in_data <= sensor_q.pop_front();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected drive beat %p", out_data);
        end else begin
          drive_t exp_d;
          exp_d = drive_q.pop_front();
          if (out_data !== exp_d) begin
            mismatches++;
            if (mismatches <= 10) $display("drive mismatch: expected %p, got %p", exp_d, out_data);
          end
        end
      end
      out_ready <= quiet_out || ($urandom_range(0, 99) >= 18);
    end
  end

  initial begin
    #2000000;
    $display("adaptive_line_follower_pid_core_tb failed");
    $finish;
  end

  initial begin
    sensor_t s;
    kp = GAIN_P_RESET; ki = GAIN_I_RESET; kd = GAIN_D_RESET;
    base_spd = BASE_SPEED_RESET; spd_lim = SPEED_LIMIT_RESET;
    dark_th = TO_DARK_RESET; white_th = TO_WHITE_RESET; smooth_w = SMOOTHING_RESET;
    avg_bright = '0; white_pol = 1'b1; integ = 0; last_err = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    sensor_q.push_back('0);
    sensor_q.push_back('1);
    sensor_q.push_back({12'd4095, 12'd0, 12'd0, 12'd0, 12'd0});
    sensor_q.push_back({12'd0, 12'd0, 12'd0, 12'd0, 12'd4095});
    sensor_q.push_back({12'd0, 12'd4095, 12'd0, 12'd0, 12'd0});
    sensor_q.push_back({12'd0, 12'd0, 12'd0, 12'd4095, 12'd0});
    sensor_q.push_back({12'd0, 12'd0, 12'd4095, 12'd0, 12'd0});
    sensor_q.push_back({12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0});
    for (int i = 0; i < 10; i++) sensor_q.push_back('1);
    for (int i = 0; i < 6; i++) sensor_q.push_back('0);
    sensor_q.push_back({12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA});
    drain_frames();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_GAIN_P, 24'hFFFFFF); write_reg(REG_GAIN_I, 24'hFFFFFF);
          write_reg(REG_GAIN_D, 24'hFFFFFF); write_reg(REG_BASE_SPEED, 24'h7FFF);
          write_reg(REG_SPEED_LIMIT, 24'h7FFF); write_reg(REG_SMOOTHING, 24'd4096);
        end
        1: begin
          write_reg(REG_GAIN_P, 24'd0); write_reg(REG_GAIN_I, 24'd0);
          write_reg(REG_GAIN_D, 24'd0); write_reg(REG_BASE_SPEED, 24'd0);
          write_reg(REG_SPEED_LIMIT, 24'd0); write_reg(REG_TO_DARK, 24'd0);
          write_reg(REG_TO_WHITE, 24'd0); write_reg(REG_SMOOTHING, 24'd0);
        end
        2: begin
          write_reg(REG_GAIN_P, GAIN_P_RESET); write_reg(REG_GAIN_I, 24'd5000);
          write_reg(REG_GAIN_D, GAIN_D_RESET); write_reg(REG_BASE_SPEED, 24'd20000);
          write_reg(REG_SPEED_LIMIT, 24'd9000); write_reg(REG_TO_DARK, 24'hFFF);
          write_reg(REG_TO_WHITE, 24'hFFF); write_reg(REG_SMOOTHING, 24'h1FFF);
        end
        3: begin
          write_reg(REG_GAIN_P, 24'hFFF000); write_reg(REG_SMOOTHING, 24'hFFE123);
          write_reg(REG_TO_DARK, 24'(TO_DARK_RESET));
          write_reg(REG_TO_WHITE, 24'(TO_WHITE_RESET));
          write_reg(REG_SPEED_LIMIT, 24'hFF7FFF);
        end
        4: begin
          write_reg(REG_GAIN_P, 24'($urandom));
          write_reg(REG_GAIN_I, 24'($urandom_range(0, 2000)));
          write_reg(REG_GAIN_D, 24'($urandom)); write_reg(REG_BASE_SPEED, 24'($urandom));
          write_reg(REG_SPEED_LIMIT, 24'($urandom)); write_reg(REG_SMOOTHING, 24'd1200);
        end
        default: begin
          write_reg(REG_GAIN_P, GAIN_P_RESET); write_reg(REG_GAIN_I, GAIN_I_RESET);
          write_reg(REG_GAIN_D, GAIN_D_RESET);
          write_reg(REG_BASE_SPEED, 24'(BASE_SPEED_RESET));
          write_reg(REG_SPEED_LIMIT, 24'(SPEED_LIMIT_RESET));
          write_reg(REG_SMOOTHING, 24'(SMOOTHING_RESET));
        end
      endcase
      quiet_in = (ph == 2);
      quiet_out = (ph == 2);
      for (int n = 0; n < 200; n++) begin
        s = rand_frame($urandom_range(0, 9) < 7 ? (n / 25) % 2 : $urandom_range(2, 3));
        sensor_q.push_back(s);
        if (ph == 3 && n == 100) begin
          do @(negedge clk); while (sensor_q.size() != 0 || in_valid);
          hold_in = 1;
          do @(negedge clk); while (drive_q.size() != 0);
          hold_in = 0;
        end
      end
      drain_frames();
    end

    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("adaptive_line_follower_pid_core_tb passed");
    end else begin
      $display("adaptive_line_follower_pid_core_tb failed");
    end
    $finish;
  end
endmodule
